FILE: rtl/core/edm_pkg.sv
// Shared types, register codes and saturating arithmetic for the edit distance matcher.
// No dependencies; every other file in rtl/core depends on this package.
package edm_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DistW   = 8;
  localparam int unsigned LenW    = 4;
  localparam int unsigned QueryW  = 64;
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = 5;

  // Register index, taken from paddr[4:3] (registers sit 8 bytes apart).
  typedef enum logic [1:0] {
    RegQueryChars   = 2'd0,
    RegQueryLength  = 2'd1,
    RegMatchDistance = 2'd2
  } reg_idx_e;

  // Data handed from one cell to the next: the candidate character, the old value of
  // the sending cell (diagonal term) and its new value (left term).
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CharW-1:0] chr;
    logic [DistW-1:0] corner;
    logic [DistW-1:0] left;
  } edm_tok_t;

  function automatic logic [DistW-1:0] sat_inc(input logic [DistW-1:0] v);
    sat_inc = (v == {DistW{1'b1}}) ? v : v + DistW'(1);
  endfunction

  function automatic logic [DistW-1:0] min3(input logic [DistW-1:0] a,
                                             input logic [DistW-1:0] b,
                                             input logic [DistW-1:0] c);
    logic [DistW-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    min3 = m;
  endfunction

endpackage

FILE: rtl/core/edm_intf.sv
// Valid/ready channel interfaces for candidate characters and distance results.
// Depends on edm_pkg for field widths.
interface edm_in_if;
  logic                      valid;
  logic                      ready;
  logic [edm_pkg::CharW-1:0] cand_char;
  logic                      last_char;

  modport source (output valid, output cand_char, output last_char, input ready);
  modport sink   (input valid, input cand_char, input last_char, output ready);
endinterface

interface edm_out_if;
  logic                      valid;
  logic                      ready;
  logic [edm_pkg::DistW-1:0] distance;
  logic                      is_match;

  modport source (output valid, output distance, output is_match, input ready);
  modport sink   (input valid, input distance, input is_match, output ready);
endinterface

FILE: rtl/core/edm_cell.sv
// One column of the Levenshtein row: holds one cell and passes the wavefront on.
// Depends on edm_pkg for the token type and saturating helpers.
module edm_cell #(
  parameter int unsigned Index = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  edm_pkg::edm_tok_t         tok_i,
  input  logic [edm_pkg::CharW-1:0] qchar_i,
  input  logic                      en_i,
  input  logic                      load_i,
  output edm_pkg::edm_tok_t         tok_o
);
  import edm_pkg::*;

  logic [DistW-1:0] cell_q;
  logic [DistW-1:0] upd;
  logic             valid_q;
  logic             last_q;
  logic [CharW-1:0] chr_q;
  logic [DistW-1:0] corner_q;
  logic [DistW-1:0] left_q;

  assign upd = (qchar_i == tok_i.chr) ? tok_i.corner
             : sat_inc(min3(tok_i.left, cell_q, tok_i.corner));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= DistW'(Index);
    end else if (load_i) begin
      cell_q <= DistW'(Index);
    end else if (tok_i.valid && en_i) begin
      cell_q <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  // Disabled cells (beyond the query length) forward the left value untouched.
  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      last_q   <= tok_i.last;
      chr_q    <= tok_i.chr;
      corner_q <= cell_q;
      left_q   <= en_i ? upd : tok_i.left;
    end
  end

  assign tok_o = '{valid: valid_q, last: last_q, chr: chr_q, corner: corner_q, left: left_q};

endmodule

FILE: rtl/core/edit_distance_match.sv
// Top level of the edit distance matcher: configuration registers, row counter,
// chain of edm_cell instances and the result register. Depends on edm_pkg and edm_intf.
//
//  Channel   Direction  Handshake          Payload
//  in_chan   sink       valid/ready        cand_char[7:0], last_char
//  out_chan  source     valid/ready        distance[7:0], is_match
//  APB       slave      psel/penable/...   64-bit registers at 8-byte spacing
//
// Each candidate character is accepted, then travels down the chain of MaxQuery cells
// one cell per clock, and the next character is accepted only once it has left the last cell.
// Reset loads cell j with j and clears the row counter, the configuration registers and the valid flags.
// A finished result waits in the output register without holding up the next word;
// a second result that arrives while the first is still waiting is parked in a spare
// register, and input transfers are refused until it moves on.
module edit_distance_match #(
  parameter int unsigned MaxQuery = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  edm_in_if.sink                              in_chan,
  edm_out_if.source                           out_chan,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [edm_pkg::ApbAddrW-1:0]        paddr,
  input  logic [edm_pkg::ApbDataW-1:0]        pwdata,
  output logic [edm_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready
);
  import edm_pkg::*;

  // Configuration registers.
  logic [QueryW-1:0] query_chars_q;
  logic [LenW-1:0]   query_length_q;
  logic [DistW-1:0]  match_distance_q;
  logic              cfg_we;
  reg_idx_e          reg_idx;

  // Row counter (cell zero of the row) and control.
  logic [DistW-1:0] row_count_q;
  logic             inflight_q;
  logic             pend_q;
  logic [DistW-1:0] pend_dist_q;
  logic             pend_match_q;
  logic             out_valid_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_match_q;

  logic             in_xfer;
  logic             exit_last;
  logic             out_free;
  logic [LenW-1:0]  n_eff;
  logic [DistW-1:0] exit_dist;
  logic             exit_match;

  edm_tok_t tok [MaxQuery+1];

  // ---------------------------------------------------------------------------
  // APB register file. pready is tied high, so a write lands in the access cycle.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_chars_q    <= '0;
      query_length_q   <= '0;
      match_distance_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        RegQueryChars:    query_chars_q    <= pwdata;
        RegQueryLength:   query_length_q   <= pwdata[LenW-1:0];
        RegMatchDistance: match_distance_q <= pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegQueryChars:    prdata = query_chars_q;
      RegQueryLength:   prdata = ApbDataW'(query_length_q);
      RegMatchDistance: prdata = ApbDataW'(match_distance_q);
      default:          prdata = '0;
    endcase
  end

  // Query lengths beyond the chain are clamped to its length.
  assign n_eff = (query_length_q > LenW'(MaxQuery)) ? LenW'(MaxQuery) : query_length_q;

  // ---------------------------------------------------------------------------
  // Input side. One character is in the chain at a time; the counter holds cell
  // zero of the row, so its old value is the first diagonal term and its
  // incremented value the first left term.
  // ---------------------------------------------------------------------------
  assign in_chan.ready = !inflight_q && !pend_q;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    tok[0].valid  = in_xfer;
    tok[0].last   = in_chan.last_char;
    tok[0].chr    = in_chan.cand_char;
    tok[0].corner = row_count_q;
    tok[0].left   = sat_inc(row_count_q);
  end

  // The token leaving the last cell carries the new value of cell n_eff.
  assign exit_last  = tok[MaxQuery].valid && tok[MaxQuery].last;
  assign exit_dist  = tok[MaxQuery].left;
  assign exit_match = (tok[MaxQuery].left == match_distance_q);

  for (genvar j = 1; j <= MaxQuery; j++) begin : g_cell
    edm_cell #(
      .Index (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[j-1]),
      .qchar_i (query_chars_q[CharW*(j-1) +: CharW]),
      .en_i    (LenW'(j) <= n_eff),
      .load_i  (exit_last),
      .tok_o   (tok[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      inflight_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        row_count_q <= sat_inc(row_count_q);
        inflight_q  <= 1'b1;
      end else if (tok[MaxQuery].valid) begin
        inflight_q <= 1'b0;
        // End of word: the row starts again from zero.
        if (tok[MaxQuery].last) begin
          row_count_q <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: a result register plus one spare for a result that finds the
  // output still occupied.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pend_q || exit_last;
      pend_q      <= 1'b0;
    end else if (exit_last) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_dist_q  <= pend_q ? pend_dist_q  : exit_dist;
      out_match_q <= pend_q ? pend_match_q : exit_match;
    end
    if (exit_last) begin
      pend_dist_q  <= exit_dist;
      pend_match_q <= exit_match;
    end
  end

  assign out_chan.valid    = out_valid_q;
  assign out_chan.distance = out_dist_q;
  assign out_chan.is_match = out_match_q;

endmodule
